[rtl/sshll_pkg.sv]
// ----------------------------------------------------------------------------
// sshll_pkg
// Shared types, constants and the sequencer program of the superspreader
// sketch update block.
// ----------------------------------------------------------------------------
package sshll_pkg;

   localparam int KEY_BITS  = 32;
   localparam int LEVEL_W   = 7;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 64;
   localparam int PC_W      = 7;

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_SEED_MAIN  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SEED_ROW4  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SEED_ROW5  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SEED_ROW6  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SEED_ROW7  = 3'd4;

   // hash constants
   localparam logic [63:0] MIX_M  = 64'hc6a4a7935bd1e995;
   localparam logic [63:0] MIX_M8 = MIX_M << 3;
   localparam logic [63:0] MIX_M4 = MIX_M << 2;
   localparam logic [63:0] MM3_C1 = 64'h87c37b91114253d5;
   localparam logic [63:0] MM3_C2 = 64'h4cf5ad432745937f;
   localparam logic [63:0] FMIX_1 = 64'hff51afd7ed558ccd;
   localparam logic [63:0] FMIX_2 = 64'hc4ceb9fe1a85ec53;
   localparam logic [63:0] MM3_LEN = 64'd12;

   // program entry points
   localparam logic [PC_W-1:0] PC_EDGE      = 7'd0;
   localparam logic [PC_W-1:0] PC_EDGE_LAST = 7'd72;
   localparam logic [PC_W-1:0] PC_ROW_LOW   = 7'd73;
   localparam logic [PC_W-1:0] PC_ROW_HIGH  = 7'd79;
   localparam logic [PC_W-1:0] PC_READ      = 7'd94;

   typedef struct packed {
      logic                 operation;
      logic [KEY_BITS-1:0]  src_key;
      logic [KEY_BITS-1:0]  dst_key;
      logic [2:0]           read_row;
      logic [9:0]           read_bucket;
      logic [6:0]           read_reg;
   } req_payload_type;

   typedef struct packed {
      logic [LEVEL_W-1:0]   edge_level;
      logic [LEVEL_W-1:0]   reg_value;
      logic [KEY_BITS-1:0]  cand_key;
      logic [LEVEL_W-1:0]   cand_level;
   } rsp_payload_type;

   typedef enum logic [4:0] {
      OP_NOP, OP_CLEAR, OP_LD_EDGE, OP_LD_K1, OP_LD_SRC, OP_LD_H1,
      OP_MUL_LL, OP_MUL_LH, OP_MUL_HL, OP_XSH47, OP_XSH33, OP_ROTL31,
      OP_ROTL33, OP_XHSEED8, OP_XSEED3, OP_XRSEED4, OP_ST_P, OP_ST_H1,
      OP_ST_H2, OP_ADD_H1, OP_ADD_H2, OP_LVL, OP_SEL_WORD, OP_ROWADDR,
      OP_ADDR1, OP_ADDR2, OP_MEMRD, OP_MEMWR, OP_RDA1, OP_RDCAP
   } dp_op_type;

   typedef enum logic [2:0] {
      CST_M, CST_C1, CST_C2, CST_F1, CST_F2
   } cst_type;

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_DISPATCH, S_RUN, S_OUT
   } ctrl_state_type;

   typedef struct packed {
      dp_op_type  op;
      cst_type    cst;
      logic       last;
   } rom_entry_type;

   typedef struct packed {
      dp_op_type  op;
      cst_type    cst;
      logic [2:0] row;
      logic       req_load;
      logic       rsp_load;
   } dp_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic is_read;
   } dp_sts_type;

   // multiplier constant select
   function automatic logic [63:0] cst_value(input cst_type c);
      logic [63:0] v;
      unique case (c)
         CST_C1:  v = MM3_C1;
         CST_C2:  v = MM3_C2;
         CST_F1:  v = FMIX_1;
         CST_F2:  v = FMIX_2;
         default: v = MIX_M;
      endcase
      return v;
   endfunction

   // trailing one bits of a byte
   function automatic logic [3:0] trail_ones8(input logic [7:0] b);
      logic [3:0] n;
      logic       stop;
      n    = 4'd0;
      stop = 1'b0;
      for (int i = 0; i < 8; i++) begin
         if (!stop && b[i]) n = n + 4'd1;
         else stop = 1'b1;
      end
      return n;
   endfunction

   // sequencer program: edge hash, source hash, row update, read
   function automatic rom_entry_type prog_rom(input logic [PC_W-1:0] pc);
      rom_entry_type e;
      e.op   = OP_NOP;
      e.cst  = CST_M;
      e.last = 1'b0;
      unique case (pc)
         7'd0:  e.op = OP_LD_EDGE;
         7'd1, 7'd5, 7'd9, 7'd13, 7'd27, 7'd31, 7'd37, 7'd41,
         7'd50, 7'd54, 7'd61, 7'd65, 7'd81, 7'd85: e.op = OP_MUL_LL;
         7'd2, 7'd6, 7'd10, 7'd14, 7'd28, 7'd32, 7'd38, 7'd42,
         7'd51, 7'd55, 7'd62, 7'd66, 7'd82, 7'd86: e.op = OP_MUL_LH;
         7'd3, 7'd7, 7'd11, 7'd15, 7'd29, 7'd33, 7'd39, 7'd43,
         7'd52, 7'd56, 7'd63, 7'd67, 7'd83, 7'd87: e.op = OP_MUL_HL;
         7'd4, 7'd12, 7'd16, 7'd84, 7'd88: e.op = OP_XSH47;
         7'd8:  e.op = OP_XHSEED8;
         7'd17: e.op = OP_ST_P;
         7'd18, 7'd19, 7'd20, 7'd21, 7'd22, 7'd23, 7'd24, 7'd25: e.op = OP_LVL;
         7'd26: e.op = OP_LD_K1;
         7'd30: e.op = OP_ROTL31;
         7'd34, 7'd44: e.op = OP_XSEED3;
         7'd35, 7'd47, 7'd70: e.op = OP_ST_H1;
         7'd36, 7'd79: e.op = OP_LD_SRC;
         7'd40: e.op = OP_ROTL33;
         7'd45, 7'd58: e.op = OP_ST_H2;
         7'd46: e.op = OP_ADD_H1;
         7'd48, 7'd69, 7'd71: e.op = OP_ADD_H2;
         7'd49, 7'd53, 7'd57, 7'd60, 7'd64, 7'd68: e.op = OP_XSH33;
         7'd59: e.op = OP_LD_H1;
         7'd72: begin
            e.op   = OP_ST_H2;
            e.last = 1'b1;
         end
         7'd73: e.op = OP_SEL_WORD;
         7'd74, 7'd89: e.op = OP_ROWADDR;
         7'd75, 7'd90, 7'd95: e.op = OP_ADDR1;
         7'd76, 7'd91, 7'd96: e.op = OP_ADDR2;
         7'd77, 7'd92, 7'd97: e.op = OP_MEMRD;
         7'd78, 7'd93: begin
            e.op   = OP_MEMWR;
            e.last = 1'b1;
         end
         7'd80: e.op = OP_XRSEED4;
         7'd94: e.op = OP_RDA1;
         7'd98: begin
            e.op   = OP_RDCAP;
            e.last = 1'b1;
         end
         default: e.last = 1'b1;
      endcase
      // multiplier constants by program range
      unique case (pc)
         7'd27, 7'd28, 7'd29, 7'd41, 7'd42, 7'd43: e.cst = CST_C1;
         7'd31, 7'd32, 7'd33, 7'd37, 7'd38, 7'd39: e.cst = CST_C2;
         7'd50, 7'd51, 7'd52, 7'd61, 7'd62, 7'd63: e.cst = CST_F1;
         7'd54, 7'd55, 7'd56, 7'd65, 7'd66, 7'd67: e.cst = CST_F2;
         default: e.cst = CST_M;
      endcase
      return e;
   endfunction

endpackage

[rtl/sshll_ram.sv]
// ----------------------------------------------------------------------------
// sshll_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module sshll_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port and registered read
   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[rtl/sshll_datapath.sv]
// ----------------------------------------------------------------------------
// sshll_datapath
// Hash accumulator with a shared 32x32 multiplier, level counter, address
// generation and the bucket and register memories.
// ----------------------------------------------------------------------------
module sshll_datapath #(
   parameter int ROWS            = 4,
   parameter int BUCKETS         = 1024,
   parameter int REGS_PER_BUCKET = 128
) (
   input  logic                             clock,
   input  logic                             reset,
   input  sshll_pkg::req_payload_type       req_data,
   output sshll_pkg::rsp_payload_type       rsp_data,
   input  logic                             csr_we,
   input  logic [sshll_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sshll_pkg::CSR_DAT_W-1:0]  csr_wdata,
   input  sshll_pkg::dp_cmd_type            cmd,
   output sshll_pkg::dp_sts_type            sts
);
   import sshll_pkg::*;

   localparam int BI_DEPTH = ROWS * BUCKETS;
   localparam int HI_DEPTH = BI_DEPTH * REGS_PER_BUCKET;
   localparam int BI_W     = $clog2(BI_DEPTH);
   localparam int HI_W     = $clog2(HI_DEPTH);
   localparam int BKT_W    = $clog2(BUCKETS);
   localparam int REG_W    = $clog2(REGS_PER_BUCKET);
   localparam int BW       = KEY_BITS + LEVEL_W;

   req_payload_type     req_ff, req_in;
   rsp_payload_type     rsp_ff, rsp_in;
   logic [63:0]         seed_main_ff, seed_main_in;
   logic [63:0]         seed_row_ff [4];
   logic [63:0]         seed_row_in [4];
   logic [63:0]         acc_ff, acc_in;
   logic [63:0]         tmp_ff, tmp_in;
   logic [63:0]         h1_ff, h1_in;
   logic [63:0]         h2_ff, h2_in;
   logic [63:0]         lvl_sh_ff, lvl_sh_in;
   logic                lvl_done_ff, lvl_done_in;
   logic [LEVEL_W-1:0]  level_ff, level_in;
   logic [REG_W-1:0]    pos_ff, pos_in;
   logic [BKT_W-1:0]    bkt_ff, bkt_in;
   logic [BI_W-1:0]     bi_ff, bi_in;
   logic [HI_W-1:0]     hi_ff, hi_in;
   logic                rd_ok_ff, rd_ok_in;
   logic                reg_ok_ff, reg_ok_in;
   logic [LEVEL_W-1:0]  res_reg_ff, res_reg_in;
   logic [KEY_BITS-1:0] res_key_ff, res_key_in;
   logic [LEVEL_W-1:0]  res_lvl_ff, res_lvl_in;
   logic [HI_W-1:0]     clr_ff, clr_in;

   logic [31:0]         mul_a, mul_b;
   logic [63:0]         prod;
   logic [63:0]         cval;
   logic [2:0]          row_sel;
   logic [31:0]         word_sel;
   logic                clr_bkt;
   logic                bkt_we, hll_we;
   logic [BI_W-1:0]     bkt_waddr;
   logic [BW-1:0]       bkt_wdata, bkt_rdata;
   logic [HI_W-1:0]     hll_waddr;
   logic [LEVEL_W-1:0]  hll_wdata, hll_rdata;

   assign cval = cst_value(cmd.cst);

   // shared multiplier operand select
   always_comb begin
      mul_a = acc_ff[31:0];
      mul_b = cval[31:0];
      unique case (cmd.op)
         OP_MUL_LH:  mul_b = cval[63:32];
         OP_MUL_HL:  mul_a = acc_ff[63:32];
         OP_ROWADDR: mul_b = 32'(BUCKETS);
         OP_ST_P: begin
            mul_a = acc_ff[63:32];
            mul_b = 32'(REGS_PER_BUCKET);
         end
         default: ;
      endcase
   end

   assign prod = 64'(mul_a) * 64'(mul_b);

   // row and hash word select
   assign row_sel = req_ff.operation ? req_ff.read_row : cmd.row;

   always_comb begin
      unique case (cmd.row[1:0])
         2'd0:    word_sel = h1_ff[31:0];
         2'd1:    word_sel = h1_ff[63:32];
         2'd2:    word_sel = h2_ff[31:0];
         default: word_sel = h2_ff[63:32];
      endcase
   end

   // configuration writes
   always_comb begin
      seed_main_in = seed_main_ff;
      seed_row_in  = seed_row_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_SEED_MAIN: seed_main_in   = csr_wdata;
            CSR_SEED_ROW4: seed_row_in[0] = csr_wdata;
            CSR_SEED_ROW5: seed_row_in[1] = csr_wdata;
            CSR_SEED_ROW6: seed_row_in[2] = csr_wdata;
            CSR_SEED_ROW7: seed_row_in[3] = csr_wdata;
            default: ;
         endcase
      end
   end

   // operation execute
   always_comb begin
      req_in      = cmd.req_load ? req_data : req_ff;
      acc_in      = acc_ff;
      tmp_in      = tmp_ff;
      h1_in       = h1_ff;
      h2_in       = h2_ff;
      lvl_sh_in   = lvl_sh_ff;
      lvl_done_in = lvl_done_ff;
      level_in    = level_ff;
      pos_in      = pos_ff;
      bkt_in      = bkt_ff;
      bi_in       = bi_ff;
      hi_in       = hi_ff;
      rd_ok_in    = rd_ok_ff;
      reg_ok_in   = reg_ok_ff;
      res_reg_in  = res_reg_ff;
      res_key_in  = res_key_ff;
      res_lvl_in  = res_lvl_ff;
      clr_in      = clr_ff;
      unique case (cmd.op)
         OP_CLEAR:    clr_in = clr_ff + HI_W'(1);
         OP_LD_EDGE:  acc_in = {req_ff.src_key, req_ff.dst_key};
         OP_LD_K1:    acc_in = {req_ff.src_key, req_ff.src_key};
         OP_LD_SRC:   acc_in = {32'd0, req_ff.src_key};
         OP_LD_H1:    acc_in = h1_ff;
         OP_MUL_LL:   tmp_in = prod;
         OP_MUL_LH:   tmp_in = tmp_ff + {prod[31:0], 32'd0};
         OP_MUL_HL:   acc_in = tmp_ff + {prod[31:0], 32'd0};
         OP_XSH47:    acc_in = acc_ff ^ (acc_ff >> 47);
         OP_XSH33:    acc_in = acc_ff ^ (acc_ff >> 33);
         OP_ROTL31:   acc_in = {acc_ff[32:0], acc_ff[63:33]};
         OP_ROTL33:   acc_in = {acc_ff[30:0], acc_ff[63:31]};
         OP_XHSEED8:  acc_in = acc_ff ^ seed_main_ff ^ MIX_M8;
         OP_XSEED3:   acc_in = acc_ff ^ {32'd0, seed_main_ff[31:0]} ^ MM3_LEN;
         OP_XRSEED4:  acc_in = acc_ff ^ seed_row_ff[cmd.row[1:0]] ^ MIX_M4;
         OP_ST_P: begin
            lvl_sh_in   = acc_ff;
            lvl_done_in = 1'b0;
            level_in    = LEVEL_W'(1);
            pos_in      = REG_W'(prod[63:32]);
         end
         OP_ST_H1:    h1_in = acc_ff;
         OP_ST_H2:    h2_in = acc_ff;
         OP_ADD_H1:   acc_in = acc_ff + h1_ff;
         OP_ADD_H2:   acc_in = acc_ff + h2_ff;
         // trailing ones, one byte a step
         OP_LVL: begin
            lvl_sh_in = lvl_sh_ff >> 8;
            if (!lvl_done_ff) begin
               if (lvl_sh_ff[7:0] == 8'hff) begin
                  level_in = level_ff + LEVEL_W'(8);
               end else begin
                  level_in    = level_ff + LEVEL_W'(trail_ones8(lvl_sh_ff[7:0]));
                  lvl_done_in = 1'b1;
               end
            end
         end
         OP_SEL_WORD: acc_in = {32'd0, word_sel};
         OP_ROWADDR:  bkt_in = BKT_W'(prod[63:32]);
         OP_ADDR1:    bi_in  = BI_W'(32'(row_sel) * 32'(BUCKETS) + 32'(bkt_ff));
         OP_ADDR2:    hi_in  = HI_W'(32'(bi_ff) * 32'(REGS_PER_BUCKET) + 32'(pos_ff));
         OP_RDA1: begin
            bkt_in    = BKT_W'(req_ff.read_bucket);
            pos_in    = REG_W'(req_ff.read_reg);
            rd_ok_in  = (32'(req_ff.read_row) < 32'(ROWS)) &&
                        (32'(req_ff.read_bucket) < 32'(BUCKETS));
            reg_ok_in = 32'(req_ff.read_reg) < 32'(REGS_PER_BUCKET);
         end
         OP_RDCAP: begin
            res_reg_in = (rd_ok_ff && reg_ok_ff) ? hll_rdata : '0;
            res_key_in = rd_ok_ff ? bkt_rdata[BW-1:LEVEL_W] : '0;
            res_lvl_in = rd_ok_ff ? bkt_rdata[LEVEL_W-1:0] : '0;
         end
         default: ;
      endcase
   end

   // result word
   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.rsp_load) begin
         if (req_ff.operation) begin
            rsp_in.edge_level = '0;
            rsp_in.reg_value  = res_reg_ff;
            rsp_in.cand_key   = res_key_ff;
            rsp_in.cand_level = res_lvl_ff;
         end else begin
            rsp_in.edge_level = level_ff;
            rsp_in.reg_value  = '0;
            rsp_in.cand_key   = '0;
            rsp_in.cand_level = '0;
         end
      end
   end

   // memory write control
   assign clr_bkt   = 32'(clr_ff) < 32'(BI_DEPTH);
   assign bkt_we    = (cmd.op == OP_CLEAR && clr_bkt) ||
                      (cmd.op == OP_MEMWR && bkt_rdata[LEVEL_W-1:0] < level_ff);
   assign bkt_waddr = (cmd.op == OP_CLEAR) ? BI_W'(clr_ff) : bi_ff;
   assign bkt_wdata = (cmd.op == OP_CLEAR) ? '0 : {req_ff.src_key, level_ff};
   assign hll_we    = (cmd.op == OP_CLEAR) ||
                      (cmd.op == OP_MEMWR && hll_rdata < level_ff);
   assign hll_waddr = (cmd.op == OP_CLEAR) ? clr_ff : hi_ff;
   assign hll_wdata = (cmd.op == OP_CLEAR) ? '0 : level_ff;

   sshll_ram #(.WIDTH(BW), .DEPTH(BI_DEPTH)) u_bucket_ram (
      .clock (clock),
      .we    (bkt_we),
      .waddr (bkt_waddr),
      .wdata (bkt_wdata),
      .raddr (bi_ff),
      .rdata (bkt_rdata)
   );

   sshll_ram #(.WIDTH(LEVEL_W), .DEPTH(HI_DEPTH)) u_hll_ram (
      .clock (clock),
      .we    (hll_we),
      .waddr (hll_waddr),
      .wdata (hll_wdata),
      .raddr (hi_ff),
      .rdata (hll_rdata)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         seed_main_ff <= '0;
         for (int i = 0; i < 4; i++) seed_row_ff[i] <= '0;
      end else begin
         clr_ff       <= clr_in;
         seed_main_ff <= seed_main_in;
         seed_row_ff  <= seed_row_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      rsp_ff      <= rsp_in;
      acc_ff      <= acc_in;
      tmp_ff      <= tmp_in;
      h1_ff       <= h1_in;
      h2_ff       <= h2_in;
      lvl_sh_ff   <= lvl_sh_in;
      lvl_done_ff <= lvl_done_in;
      level_ff    <= level_in;
      pos_ff      <= pos_in;
      bkt_ff      <= bkt_in;
      bi_ff       <= bi_in;
      hi_ff       <= hi_in;
      rd_ok_ff    <= rd_ok_in;
      reg_ok_ff   <= reg_ok_in;
      res_reg_ff  <= res_reg_in;
      res_key_ff  <= res_key_in;
      res_lvl_ff  <= res_lvl_in;
   end

   assign sts.clr_last = (clr_ff == HI_W'(HI_DEPTH - 1));
   assign sts.is_read  = req_ff.operation;
   assign rsp_data     = rsp_ff;

endmodule

[rtl/sshll_ctrl.sv]
// ----------------------------------------------------------------------------
// sshll_ctrl
// Sequencer: clearing pass, word accept, program stepping over the rows and
// result hand-off.
// ----------------------------------------------------------------------------
module sshll_ctrl #(
   parameter int ROWS = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output sshll_pkg::dp_cmd_type cmd,
   input  sshll_pkg::dp_sts_type sts
);
   import sshll_pkg::*;

   ctrl_state_type   state_ff, state_in;
   logic [PC_W-1:0]  pc_ff, pc_in;
   logic [3:0]       row_ff, row_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rom_entry_type    rom;
   logic             out_ok;
   logic [3:0]       row_nxt;

   assign rom     = prog_rom(pc_ff);
   assign out_ok  = !rsp_valid_ff || !rsp_stall;
   assign row_nxt = row_ff + 4'd1;

   // next state
   always_comb begin
      state_in = state_ff;
      pc_in    = pc_ff;
      row_in   = row_ff;
      unique case (state_ff)
         S_CLEAR: if (sts.clr_last) state_in = S_IDLE;
         S_IDLE:  if (req_valid) state_in = S_DISPATCH;
         S_DISPATCH: begin
            state_in = S_RUN;
            pc_in    = sts.is_read ? PC_READ : PC_EDGE;
         end
         S_RUN: begin
            if (!rom.last) begin
               pc_in = pc_ff + PC_W'(1);
            end else if (sts.is_read) begin
               state_in = S_OUT;
            end else if (pc_ff == PC_EDGE_LAST) begin
               row_in = 4'd0;
               pc_in  = PC_ROW_LOW;
            end else if (row_nxt == 4'(ROWS)) begin
               state_in = S_OUT;
            end else begin
               row_in = row_nxt;
               pc_in  = (row_nxt < 4'd4) ? PC_ROW_LOW : PC_ROW_HIGH;
            end
         end
         S_OUT:   if (out_ok) state_in = S_IDLE;
         default: state_in = S_CLEAR;
      endcase
   end

   // command outputs
   always_comb begin
      cmd.op       = OP_NOP;
      cmd.cst      = rom.cst;
      cmd.row      = row_ff[2:0];
      cmd.req_load = 1'b0;
      cmd.rsp_load = 1'b0;
      unique case (state_ff)
         S_CLEAR: cmd.op       = OP_CLEAR;
         S_IDLE:  cmd.req_load = req_valid;
         S_RUN:   cmd.op       = rom.op;
         S_OUT:   cmd.rsp_load = out_ok;
         default: ;
      endcase
   end

   // result valid
   always_comb begin
      if (cmd.rsp_load)    rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
      else                 rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         pc_ff        <= '0;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         row_ff       <= row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // checks
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_OUT)
      else $error("result raised outside hand-off");

   a_clear_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR && sts.clr_last) |=> state_ff == S_IDLE)
      else $error("clearing pass did not finish");

   a_row_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_RUN |-> row_ff < 4'(ROWS))
      else $error("row counter out of range");

endmodule

[rtl/superspreader_hll_sketch_update.sv]
// ----------------------------------------------------------------------------
// superspreader_hll_sketch_update
// Superspreader sketch with a HyperLogLog register array per bucket: edge
// update and register/candidate read.
//
//   channel  | ports                        | direction
//   ---------+------------------------------+----------
//   request  | req_valid, req_stall, req_data | in
//   response | rsp_valid, rsp_stall, rsp_data | out
//   config   | csr_we, csr_index, csr_wdata | in
//
// the hash chain runs through one shared 32x32 multiplier
// after reset a clearing pass over all ROWS*BUCKETS*REGS_PER_BUCKET addresses
// (524288 by default) zeroes the memories while req_stall is held
// a new word is taken while the last result still waits under rsp_stall
// ----------------------------------------------------------------------------
module superspreader_hll_sketch_update #(
   parameter int ROWS            = 4,
   parameter int BUCKETS         = 1024,
   parameter int REGS_PER_BUCKET = 128
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  sshll_pkg::req_payload_type       req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output sshll_pkg::rsp_payload_type       rsp_data,
   input  logic                             csr_we,
   input  logic [sshll_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sshll_pkg::CSR_DAT_W-1:0]  csr_wdata
);
   import sshll_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;

   sshll_ctrl #(.ROWS(ROWS)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   sshll_datapath #(
      .ROWS            (ROWS),
      .BUCKETS         (BUCKETS),
      .REGS_PER_BUCKET (REGS_PER_BUCKET)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule
